// ----- design/rid_pkg.sv -----
package rid_pkg;

    // Register indexes on the configuration channel
    localparam logic [2:0] REG_RLE_MODE    = 3'd0;
    localparam logic [2:0] REG_IMAGE_WIDTH = 3'd1;
    localparam logic [2:0] REG_DRAW_HEIGHT = 3'd2;
    localparam logic [2:0] REG_ORIGIN_X    = 3'd3;
    localparam logic [2:0] REG_ORIGIN_Y    = 3'd4;

    // Decode modes; the unused code decodes as RLE4
    localparam logic [1:0] MODE_RLE4 = 2'd0;
    localparam logic [1:0] MODE_RLE7 = 2'd1;
    localparam logic [1:0] MODE_RLE8 = 2'd2;

    localparam int MIN_WIDTH    = 8;
    localparam int CFG_DIM_W    = 10;
    localparam int COORD_W      = 16;
    localparam int LEN_W        = 9;
    localparam int BYTE_W       = 8;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QUEUE_AW     = 1;
    localparam int QUEUE_CNT_W  = 2;
    localparam int OUT_DATA_W   = 56;

    // One classified code byte handed from the front to the span engine
    typedef struct packed {
        logic                first;      // clear offsets and pairing first
        logic                pair_byte;  // RLE8 byte, run or colour by pairing state
        logic [BYTE_W-1:0]   run;
        logic [BYTE_W-1:0]   color;
    } cmd_t;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } back_state_t;

endpackage

// ----- design/rle_image_span_decoder.sv -----
// Run-length bitmap span decoder (RLE4 / RLE7 / RLE8).
//
// Input stream (s_*): one compressed code byte per transfer; s_tuser set on
// the first byte of an image clears the column/row offsets, the RLE8 pairing
// state and the finished flag before that byte is decoded.
// Output stream (m_*): one transfer per horizontal span of a run; m_tlast
// marks the final span a byte produces, m_tuser the span that completes the
// last drawn row. Bytes that produce no span (RLE8 run bytes, bytes after the
// image is finished) are consumed silently.
// Configuration (cfg_*): register writes, always ready; write only while idle.
// A byte passes through the front-end register and then the queue to the
// span engine, which picks it up in its idle state and then writes each
// span of the run into the output register in its run state, one span for
// each row that the run touches. The engine takes no new byte until the
// run's last span is registered. A two-entry queue between the byte front end and the span
// engine keeps input flowing while the engine works or the output stalls.
// When m_tready is low the pending span holds in the output register and the
// engine waits; the front end keeps taking bytes until the queue fills.
// Reset clears the offsets, pairing and finished state and loads the register
// defaults: RLE4, width 8, height 1, origin at zero.
module rle_image_span_decoder
#(
    parameter int MAX_DIMENSION = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // code byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] code_byte
    input  logic        s_tuser,   // first_byte
    // span stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [15:0] span_x, [31:16] span_y,
                                   // [40:32] span_length, [48:41] pixel_color, zero above
    output logic        m_tlast,   // last_span
    output logic        m_tuser    // image_done
);

    localparam int DIM_W = $clog2(MAX_DIMENSION);
    localparam int CW    = (DIM_W > rid_pkg::CFG_DIM_W) ? DIM_W : rid_pkg::CFG_DIM_W;

    logic [1:0]                      mode_reg;
    logic [rid_pkg::CFG_DIM_W-1:0]   width_reg;
    logic [rid_pkg::CFG_DIM_W-1:0]   height_reg;
    logic [rid_pkg::COORD_W-1:0]     origin_x_reg;
    logic [rid_pkg::COORD_W-1:0]     origin_y_reg;

    logic [CW-1:0]                   width_clamp;
    logic [CW-1:0]                   height_clamp;
    logic [DIM_W-1:0]                eff_width;
    logic [DIM_W-1:0]                eff_height;

    logic                            front_valid;
    logic                            front_ready;
    rid_pkg::cmd_t                   front_cmd;
    logic                            queue_valid;
    logic                            queue_ready;
    rid_pkg::cmd_t                   queue_cmd;

    logic [rid_pkg::COORD_W-1:0]     span_x;
    logic [rid_pkg::COORD_W-1:0]     span_y;
    logic [rid_pkg::LEN_W-1:0]       span_length;
    logic [rid_pkg::BYTE_W-1:0]      pixel_color;

    assign cfg_ready = 1'b1;

    // Register file: writes take effect at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= rid_pkg::MODE_RLE4;
            width_reg    <= rid_pkg::CFG_DIM_W'(rid_pkg::MIN_WIDTH);
            height_reg   <= rid_pkg::CFG_DIM_W'(1);
            origin_x_reg <= '0;
            origin_y_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                rid_pkg::REG_RLE_MODE:    mode_reg     <= cfg_data[1:0];
                rid_pkg::REG_IMAGE_WIDTH: width_reg    <= cfg_data[rid_pkg::CFG_DIM_W-1:0];
                rid_pkg::REG_DRAW_HEIGHT: height_reg   <= cfg_data[rid_pkg::CFG_DIM_W-1:0];
                rid_pkg::REG_ORIGIN_X:    origin_x_reg <= cfg_data;
                rid_pkg::REG_ORIGIN_Y:    origin_y_reg <= cfg_data;
                default:
                begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    // Clamp width to [MIN_WIDTH, MAX_DIMENSION-1] and height to MAX_DIMENSION-1
    always_comb
    begin
        width_clamp = CW'(width_reg);
        if (width_clamp < CW'(rid_pkg::MIN_WIDTH))
        begin
            width_clamp = CW'(rid_pkg::MIN_WIDTH);
        end
        if (width_clamp > CW'(MAX_DIMENSION - 1))
        begin
            width_clamp = CW'(MAX_DIMENSION - 1);
        end
        height_clamp = CW'(height_reg);
        if (height_clamp > CW'(MAX_DIMENSION - 1))
        begin
            height_clamp = CW'(MAX_DIMENSION - 1);
        end
    end

    assign eff_width  = width_clamp[DIM_W-1:0];
    assign eff_height = height_clamp[DIM_W-1:0];

    rid_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .rle_mode   (mode_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .code_byte  (s_tdata),
        .first_byte (s_tuser),
        .cmd_valid  (front_valid),
        .cmd_ready  (front_ready),
        .cmd        (front_cmd)
    );

    rid_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_cmd   (front_cmd),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_cmd    (queue_cmd)
    );

    rid_back #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .eff_width   (eff_width),
        .eff_height  (eff_height),
        .origin_x    (origin_x_reg),
        .origin_y    (origin_y_reg),
        .cmd_valid   (queue_valid),
        .cmd_ready   (queue_ready),
        .cmd         (queue_cmd),
        .span_valid  (m_tvalid),
        .span_ready  (m_tready),
        .span_x      (span_x),
        .span_y      (span_y),
        .span_length (span_length),
        .pixel_color (pixel_color),
        .last_span   (m_tlast),
        .image_done  (m_tuser)
    );

    assign m_tdata = {7'b0, pixel_color, span_length, span_y, span_x};

endmodule

// ----- design/rid_front.sv -----
module rid_front
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [1:0]                rle_mode,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [rid_pkg::BYTE_W-1:0] code_byte,
    input  logic                      first_byte,
    output logic                      cmd_valid,
    input  logic                      cmd_ready,
    output rid_pkg::cmd_t             cmd
);

    logic          valid_reg;
    logic          valid_next;
    rid_pkg::cmd_t cmd_reg;
    rid_pkg::cmd_t cmd_next;

    assign in_ready  = !valid_reg || cmd_ready;
    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

    // Split the byte into run and color for the current mode
    always_comb
    begin
        cmd_next.first     = first_byte;
        cmd_next.pair_byte = 1'b0;
        unique case (rle_mode)
            rid_pkg::MODE_RLE8:
            begin
                cmd_next.pair_byte = 1'b1;
                cmd_next.run       = code_byte;
                cmd_next.color     = code_byte;
            end
            rid_pkg::MODE_RLE7:
            begin
                cmd_next.run   = {1'b0, code_byte[7:1]};
                cmd_next.color = {7'b0, code_byte[0]};
            end
            default:
            begin
                cmd_next.run   = {4'b0, code_byte[7:4]};
                cmd_next.color = {4'b0, code_byte[3:0]};
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (cmd_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

// ----- design/rid_queue.sv -----
module rid_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  rid_pkg::cmd_t push_cmd,
    output logic          pop_valid,
    input  logic          pop_ready,
    output rid_pkg::cmd_t pop_cmd
);

    rid_pkg::cmd_t                    mem [rid_pkg::QUEUE_DEPTH];
    logic [rid_pkg::QUEUE_AW-1:0]     wr_ptr_reg;
    logic [rid_pkg::QUEUE_AW-1:0]     wr_ptr_next;
    logic [rid_pkg::QUEUE_AW-1:0]     rd_ptr_reg;
    logic [rid_pkg::QUEUE_AW-1:0]     rd_ptr_next;
    logic [rid_pkg::QUEUE_CNT_W-1:0]  count_reg;
    logic [rid_pkg::QUEUE_CNT_W-1:0]  count_next;
    logic                             do_push;
    logic                             do_pop;

    assign push_ready = (count_reg != rid_pkg::QUEUE_CNT_W'(rid_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- design/rid_back.sv -----
module rid_back
#(
    parameter int MAX_DIMENSION = 1024
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [$clog2(MAX_DIMENSION)-1:0]    eff_width,
    input  logic [$clog2(MAX_DIMENSION)-1:0]    eff_height,
    input  logic [rid_pkg::COORD_W-1:0]         origin_x,
    input  logic [rid_pkg::COORD_W-1:0]         origin_y,
    input  logic                                cmd_valid,
    output logic                                cmd_ready,
    input  rid_pkg::cmd_t                       cmd,
    output logic                                span_valid,
    input  logic                                span_ready,
    output logic [rid_pkg::COORD_W-1:0]         span_x,
    output logic [rid_pkg::COORD_W-1:0]         span_y,
    output logic [rid_pkg::LEN_W-1:0]           span_length,
    output logic [rid_pkg::BYTE_W-1:0]          pixel_color,
    output logic                                last_span,
    output logic                                image_done
);

    localparam int DIM_W = $clog2(MAX_DIMENSION);
    localparam int SW    = (DIM_W > rid_pkg::LEN_W) ? DIM_W : rid_pkg::LEN_W;

    rid_pkg::back_state_t state_reg;
    rid_pkg::back_state_t state_next;

    logic [DIM_W-1:0]             col_reg,   col_next;
    logic [DIM_W-1:0]             row_reg,   row_next;
    logic [rid_pkg::BYTE_W-1:0]   held_reg,  held_next;
    logic                         await_reg, await_next;
    logic                         fin_reg,   fin_next;
    logic [rid_pkg::LEN_W-1:0]    rem_reg,   rem_next;
    logic [rid_pkg::BYTE_W-1:0]   color_reg, color_next;

    logic                         out_valid_reg, out_valid_next;
    logic [rid_pkg::COORD_W-1:0]  out_x_reg,     out_x_next;
    logic [rid_pkg::COORD_W-1:0]  out_y_reg,     out_y_next;
    logic [rid_pkg::LEN_W-1:0]    out_len_reg,   out_len_next;
    logic [rid_pkg::BYTE_W-1:0]   out_color_reg, out_color_next;
    logic                         out_last_reg,  out_last_next;
    logic                         out_done_reg,  out_done_next;

    // Span arithmetic for the current position
    logic                         out_free;
    logic [DIM_W-1:0]             room;
    logic [SW-1:0]                len_ext;
    logic [rid_pkg::LEN_W-1:0]    len;
    logic [DIM_W-1:0]             end_col;
    logic [DIM_W-1:0]             row_inc;
    logic                         wraps;
    logic                         done_now;
    logic                         last_now;

    // Effective state of an incoming byte after the first-byte clear
    logic [DIM_W-1:0]             row_eff;
    logic [rid_pkg::BYTE_W-1:0]   held_eff;
    logic                         await_eff;
    logic                         fin_eff;

    assign out_free  = !out_valid_reg || span_ready;
    assign room      = eff_width - col_reg;
    assign len_ext   = (SW'(room) < SW'(rem_reg)) ? SW'(room) : SW'(rem_reg);
    assign len       = len_ext[rid_pkg::LEN_W-1:0];
    assign end_col   = DIM_W'(SW'(col_reg) + len_ext);
    assign row_inc   = row_reg + 1'b1;
    assign wraps     = (end_col >= eff_width);
    assign done_now  = wraps && (row_inc >= eff_height);
    assign last_now  = (len == rem_reg) || done_now;

    assign row_eff   = cmd.first ? '0 : row_reg;
    assign held_eff  = cmd.first ? '0 : held_reg;
    assign await_eff = cmd.first ? 1'b0 : await_reg;
    assign fin_eff   = cmd.first ? 1'b0 : fin_reg;

    assign cmd_ready   = (state_reg == rid_pkg::BK_IDLE);
    assign span_valid  = out_valid_reg;
    assign span_x      = out_x_reg;
    assign span_y      = out_y_reg;
    assign span_length = out_len_reg;
    assign pixel_color = out_color_reg;
    assign last_span   = out_last_reg;
    assign image_done  = out_done_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rid_pkg::BK_IDLE:
            begin
                if (cmd_valid && !fin_eff && (row_eff < eff_height)
                    && !(cmd.pair_byte && !await_eff))
                begin
                    state_next = rid_pkg::BK_RUN;
                end
            end
            rid_pkg::BK_RUN:
            begin
                if (row_reg >= eff_height)
                begin
                    state_next = rid_pkg::BK_IDLE;
                end
                else if (col_reg < eff_width && out_free && last_now)
                begin
                    state_next = rid_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = rid_pkg::BK_IDLE;
            end
        endcase
    end

    // Offsets, pairing state and span output
    always_comb
    begin
        col_next       = col_reg;
        row_next       = row_reg;
        held_next      = held_reg;
        await_next     = await_reg;
        fin_next       = fin_reg;
        rem_next       = rem_reg;
        color_next     = color_reg;
        out_valid_next = out_valid_reg && !span_ready;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_len_next   = out_len_reg;
        out_color_next = out_color_reg;
        out_last_next  = out_last_reg;
        out_done_next  = out_done_reg;

        unique case (state_reg)
            rid_pkg::BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.first)
                    begin
                        col_next   = '0;
                        row_next   = '0;
                        held_next  = '0;
                        await_next = 1'b0;
                        fin_next   = 1'b0;
                    end
                    if (fin_eff)
                    begin
                        // drop: image already finished
                    end
                    else if (row_eff >= eff_height)
                    begin
                        fin_next = 1'b1;
                    end
                    else if (cmd.pair_byte && !await_eff)
                    begin
                        held_next  = cmd.run;
                        await_next = 1'b1;
                    end
                    else
                    begin
                        if (cmd.pair_byte)
                        begin
                            await_next = 1'b0;
                            rem_next   = {1'b0, held_eff} + 1'b1;
                        end
                        else
                        begin
                            rem_next = {1'b0, cmd.run} + 1'b1;
                        end
                        color_next = cmd.color;
                    end
                end
            end
            rid_pkg::BK_RUN:
            begin
                if (row_reg >= eff_height)
                begin
                    fin_next = 1'b1;
                end
                else if (col_reg >= eff_width)
                begin
                    // width was lowered under the column: end the row first
                    col_next = '0;
                    row_next = row_inc;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_x_next     = origin_x + rid_pkg::COORD_W'(col_reg);
                    out_y_next     = origin_y + rid_pkg::COORD_W'(row_reg);
                    out_len_next   = len;
                    out_color_next = color_reg;
                    out_last_next  = last_now;
                    out_done_next  = done_now;
                    rem_next       = rem_reg - len;
                    if (wraps)
                    begin
                        col_next = '0;
                        row_next = row_inc;
                    end
                    else
                    begin
                        col_next = end_col;
                    end
                    if (done_now)
                    begin
                        fin_next = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rid_pkg::BK_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            held_reg      <= '0;
            await_reg     <= 1'b0;
            fin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            held_reg      <= held_next;
            await_reg     <= await_next;
            fin_reg       <= fin_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg       <= rem_next;
        color_reg     <= color_next;
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
        out_len_reg   <= out_len_next;
        out_color_reg <= out_color_next;
        out_last_reg  <= out_last_next;
        out_done_reg  <= out_done_next;
    end

endmodule

// ----- sim/rle_span_checker.sv -----
module rle_span_checker
#(
    parameter int MAX_DIMENSION = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] code_byte
    input  logic        s_tuser,   // first_byte
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,   // [15:0] span_x, [31:16] span_y,
                                   // [40:32] span_length, [48:41] pixel_color
    input  logic        m_tlast,   // last_span
    input  logic        m_tuser,   // image_done
    output int          errors,
    output int          outstanding,
    output logic        image_over
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [8:0]  length;
        logic [7:0]  color;
        logic        last;
        logic        done;
    } span_t;

    span_t spans_due[$];

    // register copies
    logic [1:0]  mode;
    logic [9:0]  width_reg;
    logic [9:0]  height_reg;
    logic [15:0] org_x;
    logic [15:0] org_y;

    // decode position
    int          col_off;
    int          row_off;
    logic [7:0]  held_run;
    logic        awaiting_color;
    logic        finished;

    function automatic int eff_width();
        int w;
        w = width_reg;
        if (w < rid_pkg::MIN_WIDTH)
            w = rid_pkg::MIN_WIDTH;
        if (w > MAX_DIMENSION - 1)
            w = MAX_DIMENSION - 1;
        return w;
    endfunction

    function automatic int eff_height();
        int h;
        h = height_reg;
        if (h > MAX_DIMENSION - 1)
            h = MAX_DIMENSION - 1;
        return h;
    endfunction

    task automatic apply_write(input logic [2:0] idx, input logic [15:0] value);
        case (idx)
            rid_pkg::REG_RLE_MODE:    mode       = value[1:0];
            rid_pkg::REG_IMAGE_WIDTH: width_reg  = value[9:0];
            rid_pkg::REG_DRAW_HEIGHT: height_reg = value[9:0];
            rid_pkg::REG_ORIGIN_X:    org_x      = value;
            rid_pkg::REG_ORIGIN_Y:    org_y      = value;
            default: ;
        endcase
    endtask

    // Lay one code byte onto the image and queue the spans it covers
    task automatic predict_spans(input logic [7:0] code, input logic first);
        int         width;
        int         height;
        int         run;
        int         remaining;
        int         len;
        int         n;
        logic [7:0] color;
        span_t      sp;
        width  = eff_width();
        height = eff_height();
        n      = 0;
        if (first)
        begin
            col_off        = 0;
            row_off        = 0;
            held_run       = '0;
            awaiting_color = 1'b0;
            finished       = 1'b0;
        end
        if (finished)
            return;
        if (row_off >= height)
        begin
            finished = 1'b1;
            return;
        end
        case (mode)
            rid_pkg::MODE_RLE8:
            begin
                if (!awaiting_color)
                begin
                    held_run       = code;
                    awaiting_color = 1'b1;
                    return;
                end
                run            = held_run;
                color          = code;
                awaiting_color = 1'b0;
            end
            rid_pkg::MODE_RLE7:
            begin
                run   = code[7:1];
                color = {7'd0, code[0]};
            end
            default:
            begin
                run   = code[7:4];
                color = {4'd0, code[3:0]};
            end
        endcase
        remaining = run + 1;
        while (remaining > 0 && n < 34)
        begin
            if (row_off >= height)
            begin
                finished = 1'b1;
                break;
            end
            // width lowered under the column: close the row before placing pixels
            if (col_off >= width)
            begin
                col_off = 0;
                row_off++;
                continue;
            end
            len = width - col_off;
            if (len > remaining)
                len = remaining;
            sp.x      = org_x + 16'(col_off);
            sp.y      = org_y + 16'(row_off);
            sp.length = 9'(len);
            sp.color  = color;
            sp.done   = 1'b0;
            n++;
            col_off   += len;
            remaining -= len;
            if (col_off >= width)
            begin
                col_off = 0;
                row_off++;
                if (row_off >= height)
                begin
                    finished = 1'b1;
                    sp.done  = 1'b1;
                end
            end
            // a span is the byte's final one when nothing more can follow it
            sp.last = (remaining == 0) || finished || (n >= 34);
            spans_due.push_back(sp);
            if (finished)
                break;
        end
    endtask

    task automatic check_span();
        span_t want;
        span_t got;
        got.x      = m_tdata[15:0];
        got.y      = m_tdata[31:16];
        got.length = m_tdata[40:32];
        got.color  = m_tdata[48:41];
        got.last   = m_tlast;
        got.done   = m_tuser;
        if (spans_due.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("unexpected span: x=%h y=%h len=%0d color=%h last=%b done=%b",
                         got.x, got.y, got.length, got.color, got.last, got.done);
            return;
        end
        want = spans_due.pop_front();
        if (got != want || m_tdata[55:49] != '0)
        begin
            errors++;
            if (errors <= 10)
            begin
                $display("span mismatch: expected x=%h y=%h len=%0d color=%h last=%b done=%b",
                         want.x, want.y, want.length, want.color, want.last, want.done);
                $display("                    got x=%h y=%h len=%0d color=%h last=%b done=%b pad=%h",
                         got.x, got.y, got.length, got.color, got.last, got.done,
                         m_tdata[55:49]);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode           = rid_pkg::MODE_RLE4;
            width_reg      = 10'd8;
            height_reg     = 10'd1;
            org_x          = '0;
            org_y          = '0;
            col_off        = 0;
            row_off        = 0;
            held_run       = '0;
            awaiting_color = 1'b0;
            finished       = 1'b0;
            spans_due.delete();
            errors         = 0;
            outstanding    = 0;
            image_over     = 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                apply_write(cfg_index, cfg_data);
            if (m_tvalid && m_tready)
                check_span();
            if (s_tvalid && s_tready)
                predict_spans(s_tdata, s_tuser);
            outstanding = spans_due.size();
            image_over  = finished || (row_off >= eff_height());
        end
    end

endmodule

// ----- sim/tb_rle_image_span_decoder.sv -----
module tb_rle_image_span_decoder;

    timeunit 1ns;
    timeprecision 1ps;

    // spare mode code; the block decodes it as RLE4
    localparam logic [1:0] MODE_SPARE   = 2'd3;
    // index past the register file; the write must change nothing
    localparam logic [2:0] REG_NONE     = 3'd5;
    localparam int         RANDOM_ITEMS = 420;
    localparam int         PHASE_ITEMS  = 36;
    localparam int         SETTLE_CYCLES = 20;
    localparam int         IDLE_LIMIT   = 2000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;   // [7:0] code_byte
    logic        s_tuser   = 1'b0; // first_byte
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [55:0] m_tdata;          // [15:0] span_x, [31:16] span_y,
                                   // [40:32] span_length, [48:41] pixel_color
    logic        m_tlast;          // last_span
    logic        m_tuser;          // image_done

    int   errors;
    int   outstanding;
    logic image_over;

    int   burst_left  = 0;
    int   ready_left  = 0;
    int   ready_style = 0;
    int   idle_cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    rle_image_span_decoder u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    rle_span_checker u_span_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .errors      (errors),
        .outstanding (outstanding),
        .image_over  (image_over)
    );

    // Span receiver: alternate long ready stretches, hard stalls and
    // cycle-by-cycle flicker so backpressure lands on every engine phase.
    always @(negedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_style = $urandom_range(0, 3);
            ready_left  = (ready_style == 2) ? $urandom_range(1, 10) : $urandom_range(4, 30);
        end
        ready_left--;
        case (ready_style)
            2:       m_tready <= 1'b0;
            3:       m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= 1'b1;
        endcase
    end

    // Watchdog: end the run if no channel moves a transfer for too long.
    always @(posedge clk)
    begin
        if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles == IDLE_LIMIT)
        begin
            $display("tb_rle_image_span_decoder failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Write one register; call only while the decoder is idle.
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Send one code byte. Hold valid across a burst; drop it for a random
    // gap at the end of each burst, then pick the next burst length.
    task automatic push_byte(input logic [7:0] code, input logic first);
        int gap;
        s_tvalid = 1'b1;
        s_tdata  = code;
        s_tuser  = first;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = $urandom_range(0, 9);
            if (gap > 0)
            begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 12);
        end
    endtask

    // Wait until every predicted span has arrived, then let the engine
    // finish any silent bytes still in its queue.
    task automatic drain();
        s_tvalid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Random screen origin, with the signed extremes mixed in
    function automatic logic [15:0] pick_origin();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        int          counted;
        int          in_phase;
        logic        first;
        logic [9:0]  w;
        logic [9:0]  h;
        logic [15:0] junk;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // --- RLE4 over a narrow image; origin x wraps past the signed max
        write_reg(rid_pkg::REG_RLE_MODE, {14'd0, rid_pkg::MODE_RLE4});
        write_reg(rid_pkg::REG_IMAGE_WIDTH, 16'd8);
        write_reg(rid_pkg::REG_DRAW_HEIGHT, 16'd4);
        write_reg(rid_pkg::REG_ORIGIN_X, 16'h7FFC);
        write_reg(rid_pkg::REG_ORIGIN_Y, 16'hFFFF);
        push_byte(8'hF3, 1'b1);  // sixteen pixels, two full rows
        push_byte(8'h00, 1'b0);
        push_byte(8'h7A, 1'b0);  // crosses a row edge
        push_byte(8'hFF, 1'b0);  // finishes the image, tail dropped
        push_byte(8'h5C, 1'b0);  // ignored after the image is done
        drain();

        // --- spare mode code decodes as RLE4
        write_reg(rid_pkg::REG_RLE_MODE, {14'd0, MODE_SPARE});
        push_byte(8'h3C, 1'b1);
        drain();

        // --- RLE7, width below the minimum, tallest image
        write_reg(rid_pkg::REG_RLE_MODE, {14'd0, rid_pkg::MODE_RLE7});
        write_reg(rid_pkg::REG_IMAGE_WIDTH, 16'd3);
        write_reg(rid_pkg::REG_DRAW_HEIGHT, 16'd1023);
        push_byte(8'hFF, 1'b1);  // 128 pixels across sixteen rows
        push_byte(8'h00, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(8'hFE, 1'b0);
        drain();

        // --- RLE8 pairs on the widest image; first byte mid-pair resets pairing
        write_reg(rid_pkg::REG_RLE_MODE, {14'd0, rid_pkg::MODE_RLE8});
        write_reg(rid_pkg::REG_IMAGE_WIDTH, 16'd1023);
        write_reg(rid_pkg::REG_ORIGIN_X, 16'h8000);
        write_reg(rid_pkg::REG_ORIGIN_Y, 16'h7FFF);
        push_byte(8'hFF, 1'b1);
        push_byte(8'hAB, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h05, 1'b0);
        push_byte(8'h10, 1'b1);
        push_byte(8'h00, 1'b0);
        drain();

        // --- longest run from the last column of a narrow row: most spans per byte
        write_reg(rid_pkg::REG_IMAGE_WIDTH, 16'd8);
        push_byte(8'h06, 1'b1);
        push_byte(8'h01, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hC3, 1'b0);
        drain();

        // --- width lowered under the current column
        write_reg(rid_pkg::REG_RLE_MODE, {14'd0, rid_pkg::MODE_RLE4});
        write_reg(rid_pkg::REG_IMAGE_WIDTH, 16'd20);
        push_byte(8'hE5, 1'b1);
        drain();
        write_reg(rid_pkg::REG_IMAGE_WIDTH, 16'd10);
        push_byte(8'h21, 1'b0);
        drain();

        // --- zero height: every byte is ignored
        write_reg(rid_pkg::REG_DRAW_HEIGHT, 16'd0);
        write_reg(REG_NONE, 16'hFFFF);
        push_byte(8'h11, 1'b0);
        push_byte(8'h22, 1'b1);
        drain();

        // --- height lowered under the current row
        write_reg(rid_pkg::REG_IMAGE_WIDTH, 16'd8);
        write_reg(rid_pkg::REG_DRAW_HEIGHT, 16'd1023);
        push_byte(8'hF0, 1'b1);
        push_byte(8'hF0, 1'b0);
        push_byte(8'hF0, 1'b0);
        drain();
        write_reg(rid_pkg::REG_DRAW_HEIGHT, 16'd3);
        push_byte(8'h44, 1'b0);
        drain();

        // --- random phases: new settings each phase, images restarted once
        // they finish so few bytes land on a finished image
        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            drain();
            case ($urandom_range(0, 9))
                0:       w = 10'($urandom_range(0, 7));
                1:       w = 10'd1023;
                2:       w = 10'd8;
                default: w = 10'($urandom_range(8, 40));
            endcase
            case ($urandom_range(0, 11))
                0:       h = 10'd0;
                1:       h = 10'd1023;
                2:       h = 10'd1;
                default: h = 10'($urandom_range(1, 12));
            endcase
            junk = 16'($urandom);
            write_reg(rid_pkg::REG_RLE_MODE, {junk[15:2], 2'($urandom_range(0, 3))});
            junk = 16'($urandom);
            write_reg(rid_pkg::REG_IMAGE_WIDTH, {junk[15:10], w});
            junk = 16'($urandom);
            write_reg(rid_pkg::REG_DRAW_HEIGHT, {junk[15:10], h});
            write_reg(rid_pkg::REG_ORIGIN_X, pick_origin());
            write_reg(rid_pkg::REG_ORIGIN_Y, pick_origin());
            if ($urandom_range(0, 7) == 0)
                write_reg(REG_NONE + 3'($urandom_range(0, 2)), 16'($urandom));

            // keep the current image going across some phase boundaries
            in_phase = 0;
            first    = ($urandom_range(0, 2) != 0);
            while (in_phase < PHASE_ITEMS && counted < RANDOM_ITEMS)
            begin
                if (image_over && !first)
                    first = ($urandom_range(0, 9) != 0);
                if (first || !image_over)
                begin
                    counted++;
                    in_phase++;
                end
                push_byte(8'($urandom), first);
                first = ($urandom_range(0, 49) == 0);
            end
        end
        drain();

        if (errors == 0)
            $display("tb_rle_image_span_decoder passed");
        else
            $display("tb_rle_image_span_decoder failed");
        $finish;
    end

endmodule

// ----- sim.f -----
design/rid_pkg.sv
design/rid_front.sv
design/rid_queue.sv
design/rid_back.sv
design/rle_image_span_decoder.sv
sim/rle_span_checker.sv
sim/tb_rle_image_span_decoder.sv
